// ----- src/lmb_pkg.sv -----
// shared types and constants for the level meter ballistics and peak hold block
// no dependencies; used by the interfaces and every module in src
`timescale 1ns / 1ps
`default_nettype none

package lmb_pkg;

  localparam int SEGMENTS  = 24;
  localparam int LVL_W     = 17;
  localparam int COEF_W    = 16;
  localparam int HOLD_W    = 8;
  localparam int FRAC_W    = 16;
  localparam int PROD_W    = LVL_W + COEF_W;
  localparam int SEG_W     = 5;
  localparam int ADDR_W    = 4;
  localparam int DATA_W    = 32;

  typedef logic [LVL_W-1:0]  lvl_t;
  typedef logic [COEF_W-1:0] coef_t;
  typedef logic [HOLD_W-1:0] hold_t;
  typedef logic [PROD_W-1:0] prod_t;

  localparam lvl_t  FULL_SCALE = lvl_t'(1) << FRAC_W;
  localparam lvl_t  SEG_LAST   = lvl_t'(SEGMENTS - 1);
  localparam coef_t SEG_OP     = coef_t'(SEGMENTS);

  localparam coef_t ATTACK_RST  = coef_t'(39322);
  localparam coef_t RELEASE_RST = coef_t'(2621);
  localparam coef_t DECAY_RST   = coef_t'(524);
  localparam hold_t HOLD_RST    = hold_t'(30);

  typedef struct packed {
    coef_t attack_coef;
    coef_t release_coef;
    coef_t peak_decay_step;
    hold_t hold_ticks;
  } cfg_t;

  typedef struct packed {
    lvl_t  a;
    coef_t b;
  } mul_op_t;

  typedef enum logic [1:0] {
    REG_ATTACK  = 2'd0,
    REG_RELEASE = 2'd1,
    REG_DECAY   = 2'd2,
    REG_HOLD    = 2'd3
  } reg_idx_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_APPLY,
    S_PEAK,
    S_LIT,
    S_OUT
  } state_t;

endpackage

`default_nettype wire

// ----- src/lmb_ifs.sv -----
// valid/ready channel interfaces for the level input and the meter result
// depends on lmb_pkg
`timescale 1ns / 1ps
`default_nettype none

interface lmb_in_if
  import lmb_pkg::*;
;
  logic valid;
  logic ready;
  lvl_t level;

  modport source (output valid, output level, input ready);
  modport sink   (input valid, input level, output ready);
endinterface

interface lmb_out_if
  import lmb_pkg::*;
;
  logic             valid;
  logic             ready;
  logic [SEG_W-1:0] lit_count;
  logic [SEG_W-1:0] peak_index;
  logic             peak_shown;
  lvl_t             shown_level;
  lvl_t             peak_value;

  modport source (output valid, output lit_count, output peak_index, output peak_shown,
                  output shown_level, output peak_value, input ready);
  modport sink   (input valid, input lit_count, input peak_index, input peak_shown,
                  input shown_level, input peak_value, output ready);
endinterface

`default_nettype wire

// ----- src/lmb_cfg.sv -----
// apb-style configuration registers: coefficients, peak decay step, hold length
// depends on lmb_pkg
`timescale 1ns / 1ps
`default_nettype none

module lmb_cfg
  import lmb_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [DATA_W-1:0] pwdata,
  output logic      [DATA_W-1:0] prdata,
  output logic                   pready,
  output cfg_t                   cfg
);

  reg_idx_t idx;
  logic     wr_en;

  assign idx    = reg_idx_t'(paddr[3:2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.attack_coef     <= ATTACK_RST;
      cfg.release_coef    <= RELEASE_RST;
      cfg.peak_decay_step <= DECAY_RST;
      cfg.hold_ticks      <= HOLD_RST;
    end else if (wr_en) begin
      case (idx)
        REG_ATTACK:  cfg.attack_coef     <= pwdata[COEF_W-1:0];
        REG_RELEASE: cfg.release_coef    <= pwdata[COEF_W-1:0];
        REG_DECAY:   cfg.peak_decay_step <= pwdata[COEF_W-1:0];
        REG_HOLD:    cfg.hold_ticks      <= pwdata[HOLD_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_ATTACK:  prdata = DATA_W'(cfg.attack_coef);
      REG_RELEASE: prdata = DATA_W'(cfg.release_coef);
      REG_DECAY:   prdata = DATA_W'(cfg.peak_decay_step);
      REG_HOLD:    prdata = DATA_W'(cfg.hold_ticks);
      default:     prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

// ----- src/lmb_mul.sv -----
// shared 17x16 unsigned multiplier with registered product
// depends on lmb_pkg
`timescale 1ns / 1ps
`default_nettype none

module lmb_mul
  import lmb_pkg::*;
(
  input  wire logic    clk,
  input  wire mul_op_t op,
  output prod_t        prod
);

  always_ff @(posedge clk) begin
    prod <= PROD_W'(op.a) * PROD_W'(op.b);
  end

endmodule

`default_nettype wire

// ----- src/lmb_core.sv -----
// sequencer and state for meter ballistics and peak hold, result register
// depends on lmb_pkg, lmb_ifs and lmb_mul
`timescale 1ns / 1ps
`default_nettype none

module lmb_core
  import lmb_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire cfg_t cfg,
  lmb_in_if.sink    in_ch,
  lmb_out_if.source out_ch
);

  state_t           state, state_next;
  lvl_t             disp;
  lvl_t             peak;
  hold_t            hold;
  lvl_t             diff;
  logic             rising;
  logic [SEG_W-1:0] lit;
  mul_op_t          op;
  prod_t            prod;

  logic             out_valid;
  logic [SEG_W-1:0] out_lit;
  logic [SEG_W-1:0] out_pidx;
  logic             out_held;
  lvl_t             out_disp;
  lvl_t             out_peak;

  logic             accept;
  logic             out_free;
  logic             load_out;
  lvl_t             lvl_c;
  logic             rising_c;
  lvl_t             step_up;
  logic [PROD_W:0]  rnd;
  logic [LVL_W:0]   step_dn;
  lvl_t             disp_next;
  lvl_t             prod_hi;
  lvl_t             pidx_full;

  lmb_mul u_mul (
    .clk  (clk),
    .op   (op),
    .prod (prod)
  );

  assign accept   = in_ch.valid && in_ch.ready;
  assign out_free = !out_valid || out_ch.ready;
  assign load_out = (state == S_OUT) && out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next  = state;
    in_ch.ready = 1'b0;
    op.a        = diff;
    op.b        = rising ? cfg.attack_coef : cfg.release_coef;
    case (state)
      S_IDLE: begin
        in_ch.ready = 1'b1;
        if (in_ch.valid) begin
          state_next = S_MUL;
        end
      end
      S_MUL: begin
        state_next = S_APPLY;
      end
      S_APPLY: begin
        state_next = S_PEAK;
      end
      S_PEAK: begin
        op.a       = disp;
        op.b       = SEG_OP;
        state_next = S_LIT;
      end
      S_LIT: begin
        op.a       = peak;
        op.b       = SEG_OP;
        state_next = S_OUT;
      end
      S_OUT: begin
        // keep the peak product steady while the result waits
        op.a = peak;
        op.b = SEG_OP;
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // input clamp and direction of the one-pole step
  assign lvl_c    = (in_ch.level > FULL_SCALE) ? FULL_SCALE : in_ch.level;
  assign rising_c = lvl_c > disp;

  // floor rounding: downward step is the ceiling of its size
  assign step_up   = prod[PROD_W-1:FRAC_W];
  assign rnd       = {1'b0, prod} + (PROD_W + 1)'(16'hFFFF);
  assign step_dn   = rnd[PROD_W:FRAC_W];
  assign disp_next = rising ? disp + step_up : LVL_W'({1'b0, disp} - step_dn);

  assign prod_hi   = prod[PROD_W-1:FRAC_W];
  assign pidx_full = (prod_hi > SEG_LAST) ? SEG_LAST : prod_hi;

  always_ff @(posedge clk) begin
    if (rst) begin
      disp <= '0;
      peak <= '0;
      hold <= '0;
    end else begin
      case (state)
        S_APPLY: begin
          disp <= disp_next;
        end
        S_PEAK: begin
          if (disp > peak) begin
            peak <= disp;
            hold <= cfg.hold_ticks;
          end else if (hold != '0) begin
            hold <= hold - hold_t'(1);
          end else if (peak > lvl_t'(cfg.peak_decay_step)) begin
            peak <= peak - lvl_t'(cfg.peak_decay_step);
          end else begin
            peak <= '0;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rising <= rising_c;
      diff   <= rising_c ? lvl_c - disp : disp - lvl_c;
    end
    if (state == S_LIT) begin
      lit <= prod[FRAC_W +: SEG_W];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_lit  <= lit;
      out_pidx <= pidx_full[SEG_W-1:0];
      out_held <= hold != '0;
      out_disp <= disp;
      out_peak <= peak;
    end
  end

  assign out_ch.valid       = out_valid;
  assign out_ch.lit_count   = out_lit;
  assign out_ch.peak_index  = out_pidx;
  assign out_ch.peak_shown  = out_held;
  assign out_ch.shown_level = out_disp;
  assign out_ch.peak_value  = out_peak;

  a_disp_range: assert property (@(posedge clk) disable iff (rst) disp <= FULL_SCALE)
    else $error("shown level above full scale");

  a_peak_range: assert property (@(posedge clk) disable iff (rst) peak <= FULL_SCALE)
    else $error("peak above full scale");

  a_accept_seq: assert property (@(posedge clk) disable iff (rst)
    accept |=> state == S_MUL)
    else $error("accepted item did not start the multiply");

  a_out_from_seq: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == S_OUT)
    else $error("result raised outside the output step");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ch.ready |=> out_valid && $stable(out_disp) && $stable(out_peak))
    else $error("waiting result item changed");

endmodule

`default_nettype wire

// ----- src/level_meter_ballistics_peak_hold.sv -----
// level meter ballistics with peak hold: one result item per level item
// the sequencer takes each item through the multiply, apply, peak, lit and output steps, one item at a time,
// as the single shared multiplier is used for the step, lit count and peak index in turn
// ready is high only while the sequencer idles; the result register lets the next item in
// reset (rst, synchronous): shown level, peak and hold count cleared, registers to defaults
// depends on lmb_pkg, lmb_ifs, lmb_cfg, lmb_mul, lmb_core
`timescale 1ns / 1ps
`default_nettype none

module level_meter_ballistics_peak_hold
  import lmb_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  lmb_in_if.sink                 in_ch,
  lmb_out_if.source              out_ch,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [DATA_W-1:0] pwdata,
  output logic      [DATA_W-1:0] prdata,
  output logic                   pready
);

  cfg_t cfg;

  lmb_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  lmb_core u_core (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

endmodule

`default_nettype wire
